// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, types and helpers for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // built entry count and derived widths
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int KEY_W = 10;
  localparam int VAL_W = 11;
  localparam int CAP_W = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
    logic op_set;
  } status_t;

  // effective capacity: zero acts as one, clipped to the built entry count
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] res;
    if (c == '0) begin
      res = CNT_W'(1);
    end else if (int'(c) > ENTRIES) begin
      res = CNT_W'(ENTRIES);
    end else begin
      res = CNT_W'(c);
    end
    return res;
  endfunction

endpackage

// File: rtl/lkv_req_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if
// Request channel: valid/ready handshake carrying one get or set word.
// ----------------------------------------------------------------------------
interface lkv_req_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [lkv_pkg::KEY_W-1:0] key;
  logic [lkv_pkg::VAL_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

// File: rtl/lkv_rsp_if.sv
// ----------------------------------------------------------------------------
// lkv_rsp_if
// Response channel: valid/ready handshake carrying one lookup result word.
// ----------------------------------------------------------------------------
interface lkv_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lkv_pkg::VAL_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// File: rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-set replacement (gets leave recency unchanged).
// ----------------------------------------------------------------------------
// Sequence: an accepted get scans each entry in use, then loads the result
//   register once the previous result has been taken; a set scans, then commits
//   and gives no response. A new word is accepted only in idle, so one word is
//   fully through before the next is taken.
// Reset (rst_n low, synchronous): all entries invalid, ranks in index order,
//   capacity 32; no clearing pass, words are accepted right after reset.
module lru_key_value_cache_core (
  input  logic                      clk,
  input  logic                      rst_n,
  lkv_req_if.sink                   in_ch,
  lkv_rsp_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);

  lkv_pkg::cmd_t    cmd;
  lkv_pkg::status_t status;

  // controller
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  lkv_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_operation   (in_ch.operation),
    .in_key         (in_ch.key),
    .in_value       (in_ch.value),
    .out_hit        (out_ch.hit),
    .out_read_value (out_ch.read_value)
  );

endmodule

// File: rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry storage, recency ranks, one-entry-per-cycle scan and result register.
// ----------------------------------------------------------------------------
module lkv_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkv_pkg::cmd_t               cmd,
  output lkv_pkg::status_t            status,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                        in_operation,
  input  logic [lkv_pkg::KEY_W-1:0]   in_key,
  input  logic [lkv_pkg::VAL_W-1:0]   in_value,
  output logic                        out_hit,
  output logic [lkv_pkg::VAL_W-1:0]   out_read_value
);

  // entry storage
  logic [lkv_pkg::KEY_W-1:0] entry_key_r   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] entry_value_r [lkv_pkg::ENTRIES];
  logic [lkv_pkg::ENTRIES-1:0] entry_valid_r;
  logic [lkv_pkg::IDX_W-1:0] rank_r        [lkv_pkg::ENTRIES];

  // configuration and captured request
  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic                      op_r;
  logic [lkv_pkg::KEY_W-1:0] key_r;
  logic [lkv_pkg::VAL_W-1:0] val_r;

  // scan state
  logic [lkv_pkg::IDX_W-1:0] scan_idx_r;
  logic                      hit_r;
  logic [lkv_pkg::IDX_W-1:0] hit_idx_r;
  logic [lkv_pkg::IDX_W-1:0] hit_rank_r;
  logic [lkv_pkg::VAL_W-1:0] hit_val_r;
  logic                      free_r;
  logic [lkv_pkg::IDX_W-1:0] free_idx_r;
  logic [lkv_pkg::IDX_W-1:0] free_rank_r;
  logic [lkv_pkg::IDX_W-1:0] best_idx_r;
  logic [lkv_pkg::IDX_W-1:0] best_rank_r;

  // result register
  logic                      out_hit_r;
  logic [lkv_pkg::VAL_W-1:0] out_val_r;

  logic [lkv_pkg::CNT_W-1:0] ecap;
  logic [lkv_pkg::CNT_W-1:0] ecap_new;
  logic [lkv_pkg::KEY_W-1:0] cur_key;
  logic [lkv_pkg::VAL_W-1:0] cur_val;
  logic [lkv_pkg::IDX_W-1:0] cur_rank;
  logic                      cur_valid;
  logic                      cur_match;
  logic [lkv_pkg::IDX_W-1:0] sel;
  logic [lkv_pkg::IDX_W-1:0] sel_rank;

  assign ecap     = lkv_pkg::eff_cap(cap_r);
  assign ecap_new = lkv_pkg::eff_cap(cfg_wdata);

  // entry under the scan pointer
  assign cur_key   = entry_key_r[scan_idx_r];
  assign cur_val   = entry_value_r[scan_idx_r];
  assign cur_rank  = rank_r[scan_idx_r];
  assign cur_valid = entry_valid_r[scan_idx_r];
  assign cur_match = cur_valid && (cur_key == key_r);

  assign status.scan_last = (lkv_pkg::CNT_W'(scan_idx_r) + lkv_pkg::CNT_W'(1)) == ecap;
  assign status.op_set    = (op_r == lkv_pkg::OP_SET);

  // victim choice: matching entry, else first free, else least recent
  always_comb begin
    if (hit_r) begin
      sel      = hit_idx_r;
      sel_rank = hit_rank_r;
    end else if (free_r) begin
      sel      = free_idx_r;
      sel_rank = free_rank_r;
    end else begin
      sel      = best_idx_r;
      sel_rank = best_rank_r;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_operation;
      key_r       <= in_key;
      val_r       <= in_value;
      scan_idx_r  <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      best_rank_r <= '0;
      best_idx_r  <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + lkv_pkg::IDX_W'(1);
      if (cur_match && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= scan_idx_r;
        hit_rank_r <= cur_rank;
        hit_val_r  <= cur_val;
      end
      if (!cur_valid && !free_r) begin
        free_r      <= 1'b1;
        free_idx_r  <= scan_idx_r;
        free_rank_r <= cur_rank;
      end
      if (cur_rank >= best_rank_r) begin
        best_rank_r <= cur_rank;
        best_idx_r  <= scan_idx_r;
      end
    end
  end

  // key and value writes on commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      entry_value_r[sel] <= val_r;
      if (!hit_r) begin
        entry_key_r[sel] <= key_r;
      end
    end
  end

  // valid bits: set on fill, cleared beyond capacity on config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (i >= int'(ecap_new)) begin
          entry_valid_r[i] <= 1'b0;
        end
      end
    end else if (cmd.commit) begin
      entry_valid_r[sel] <= 1'b1;
    end
  end

  // recency ranks: chosen entry to zero, younger ones age by one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        rank_r[i] <= lkv_pkg::IDX_W'(i);
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (lkv_pkg::IDX_W'(i) == sel) begin
          rank_r[i] <= '0;
        end else if (rank_r[i] < sel_rank) begin
          rank_r[i] <= rank_r[i] + lkv_pkg::IDX_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r <= hit_r;
      out_val_r <= hit_r ? hit_val_r : '0;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

endmodule

// File: rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Controller: accepts a word, sequences the scan, commit and response.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lkv_pkg::status_t status,
  output lkv_pkg::cmd_t    cmd
);

  lkv_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      lkv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = lkv_pkg::ST_SCAN;
        end
      end
      lkv_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = status.op_set ? lkv_pkg::ST_COMMIT : lkv_pkg::ST_RESP;
        end
      end
      lkv_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = lkv_pkg::ST_IDLE;
      end
      lkv_pkg::ST_RESP: begin
        // wait for the result register to drain
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
